// ===== hw/rtl/double_ended_queue_unit_assert.svh =====
// Assertion macros for the double-ended queue unit checker.
// Depends on nothing; included by the checker file.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DEQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

// ===== hw/rtl/deq_pkg.sv =====
// Shared types, constants and ring arithmetic for the double-ended queue unit.
// No dependencies.
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_PUSH_TAIL = 2'd0,
      ACT_PUSH_HEAD = 2'd1,
      ACT_POP_TAIL  = 2'd2,
      ACT_POP_HEAD  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      action_type            action;
      logic [DATA_WIDTH-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data_out;
      status_type            status;
      logic [CNT_W-1:0]      entry_count;
      logic                  is_empty;
   } rsp_type;

   typedef struct packed {
      logic take_req;
      logic execute;
      logic load_rsp;
   } cmd_type;

   // (base + offset) mod DEPTH, both operands below DEPTH
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] offset);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (PTR_W+1)'(DEPTH)) begin
         sum = sum - (PTR_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // (base - 1) mod DEPTH
   function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] base);
      logic [PTR_W-1:0] res;
      if (base == '0) begin
         res = PTR_W'(DEPTH - 1);
      end else begin
         res = base - PTR_W'(1);
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/deq_datapath.sv =====
// Datapath of the double-ended queue unit: request register, head pointer, entry count,
// entry memory and result register. Depends on deq_pkg.
module deq_datapath import deq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_payload,
   output rsp_type rsp_payload
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   req_type               req_ff;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  pop_ok_ff;
   status_type            status_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  full, empty, is_push, op_ok;
   logic [CNT_W-1:0]      count_m1;
   logic [PTR_W-1:0]      slot;
   status_type            status_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign is_push  = (req_ff.action == ACT_PUSH_TAIL) || (req_ff.action == ACT_PUSH_HEAD);
   assign op_ok    = is_push ? !full : !empty;
   assign count_m1 = count_ff - CNT_W'(1);

   // pick the ring slot this request touches
   always_comb begin
      unique case (req_ff.action)
         ACT_PUSH_TAIL: slot = ring_add(head_ff, count_ff[PTR_W-1:0]);
         ACT_PUSH_HEAD: slot = ring_dec(head_ff);
         ACT_POP_TAIL:  slot = ring_add(head_ff, count_m1[PTR_W-1:0]);
         default:       slot = head_ff;
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.execute && op_ok) begin
         case (req_ff.action)
            ACT_PUSH_TAIL: count_in = count_ff + CNT_W'(1);
            ACT_PUSH_HEAD: begin
               head_in  = slot;
               count_in = count_ff + CNT_W'(1);
            end
            ACT_POP_TAIL:  count_in = count_m1;
            default: begin
               head_in  = ring_add(head_ff, PTR_W'(1));
               count_in = count_m1;
            end
         endcase
      end
   end

   always_comb begin
      if (op_ok) begin
         status_in = ST_DONE;
      end else if (is_push) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_EMPTY;
      end
   end

   always_comb begin
      rsp_in.data_out    = pop_ok_ff ? rd_data_ff : '0;
      rsp_in.status      = status_ff;
      rsp_in.entry_count = count_ff;
      rsp_in.is_empty    = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_ff <= req_payload;
      end
      if (cmd.execute) begin
         pop_ok_ff <= op_ok && !is_push;
         status_ff <= status_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (op_ok && is_push) begin
            mem[slot] <= req_ff.data_in;
         end
         rd_data_ff <= mem[slot];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Controller of the double-ended queue unit: sequences capture, execute and
// result load, and owns both handshakes. Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_RESP;
         S_RESP: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.take_req = 1'b0;
      cmd.execute  = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
         end
         S_EXEC: cmd.execute = 1'b1;
         S_RESP: cmd.load_rsp = out_free;
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------
//   req     | req_valid / req_ready | req_type: action, data_in
//   rsp     | rsp_valid / rsp_ready | rsp_type: data_out, status,
//           |                       |           entry_count, is_empty
//
// Each request runs capture, ring update with the entry memory access
// (its registered read port sets the extra step), then result load.
// Reset clears the head position, the entry count, the controller state and
// the result valid flag; the entry memory is not cleared.
// A result waits in the output register while the next request is taken;
// that request holds in its result step until the waiting result transfers.
module double_ended_queue_unit import deq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   deq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hw/rtl/deq_checker.sv =====
// Port-level checks for the double-ended queue unit, bound to the top level.
// Depends on deq_pkg and double_ended_queue_unit_assert.svh.
`include "double_ended_queue_unit_assert.svh"

module deq_checker import deq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic             req_stall, rsp_stall, rsp_failed, rsp_empty;
   logic [CNT_W-1:0] rsp_count;

   assign req_stall  = req_valid && !req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_failed = rsp_valid && (rsp_payload.status != ST_DONE);
   assign rsp_count  = rsp_payload.entry_count;
   assign rsp_empty  = rsp_payload.is_empty;

   // a stalled request holds
   `DEQ_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, req_valid && $stable(req_payload))

   // a stalled result holds
   `DEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   `DEQ_ASSERT_IMPLY(a_count_bound, clock, reset, rsp_valid, rsp_count <= CNT_W'(DEPTH))

   `DEQ_ASSERT_IMPLY(a_empty_flag, clock, reset, rsp_valid, rsp_empty == (rsp_count == '0))

   // failed requests return no data
   `DEQ_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_failed, rsp_payload.data_out == '0)

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);

// ===== tb/double_ended_queue_unit_tb.sv =====
// Self-checking testbench for double_ended_queue_unit: a directed fill/drain
// pass plus biased random push/pop traffic with bursty requests and stalled results.
// Depends on deq_pkg and the double_ended_queue_unit RTL.
`timescale 1ns / 100ps

module double_ended_queue_unit_tb;
   import deq_pkg::*;

   localparam int CLK_HALF         = 10;
   localparam int RESET_CYCLES     = 12;
   localparam int RANDOM_ITEMS     = 1700;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int TAIL_CYCLES      = 12;

   typedef struct {
      bit      drain_point;
      req_type req;
   } queued_req_type;

   typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   double_ended_queue_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Shadow copy of the deque
   logic [DATA_WIDTH-1:0] ring_words [DEPTH];
   int ring_head = 0;
   int ring_count = 0;

   int push_total = 0;
   int pop_total = 0;
   int full_rejects = 0;
   int empty_pops = 0;
   int peak_fill = 0;
   int mismatches = 0;

   queued_req_type queued_requests[$];
   rsp_type        awaited_results[$];

   function automatic rsp_type predict_deque_result(req_type r);
      rsp_type res;
      res = '0;
      res.status = ST_DONE;
      if (r.action == ACT_PUSH_TAIL || r.action == ACT_PUSH_HEAD) begin
         push_total++;
         if (ring_count >= DEPTH) begin
            res.status = ST_FULL;
            full_rejects++;
         end else if (r.action == ACT_PUSH_TAIL) begin
            ring_words[(ring_head + ring_count) % DEPTH] = r.data_in;
            ring_count++;
         end else begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_words[ring_head] = r.data_in;
            ring_count++;
         end
      end else begin
         pop_total++;
         if (ring_count == 0) begin
            res.status = ST_EMPTY;
            empty_pops++;
         end else if (r.action == ACT_POP_TAIL) begin
            res.data_out = ring_words[(ring_head + ring_count - 1) % DEPTH];
            ring_count--;
         end else begin
            res.data_out = ring_words[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
            ring_count--;
         end
      end
      res.entry_count = CNT_W'(ring_count);
      res.is_empty = (ring_count == 0);
      if (ring_count > peak_fill) begin
         peak_fill = ring_count;
      end
      return res;
   endfunction

   task automatic add_request(action_type act, logic [DATA_WIDTH-1:0] word);
      queued_req_type item;
      item.drain_point = 1'b0;
      item.req.action = act;
      item.req.data_in = word;
      queued_requests.push_back(item);
   endtask

   task automatic add_drain_point();
      queued_req_type item;
      item.drain_point = 1'b1;
      item.req = '0;
      queued_requests.push_back(item);
   endtask

   function automatic logic [DATA_WIDTH-1:0] random_word();
      logic [DATA_WIDTH-1:0] w;
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = '1;
         2: w = DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1);
         default: w = DATA_WIDTH'($urandom);
      endcase
      return w;
   endfunction

   // Request driver: bursts of transfers separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   queued_req_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(predict_deque_result(req_payload));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_requests.size() == 0) begin
               req_valid <= 1'b0;
            end else if (queued_requests[0].drain_point) begin
               // hold off until every outstanding result has come back
               req_valid <= 1'b0;
               if (awaited_results.size() == 0) begin
                  queued_requests.delete(0);
               end
            end else begin
               next_item = queued_requests.pop_front();
               req_valid <= 1'b1;
               req_payload <= next_item.req;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Result monitor and receiver stall pattern
   int rx_cycle = 0;
   int results_seen = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   rx_mode_type rx_mode;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result transfer, actual %p", $time, rsp_payload);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_payload.data_out !== want.data_out) begin
                  mismatches++;
                  $display("%0t: data_out expected %h actual %h", $time,
                           want.data_out, rsp_payload.data_out);
               end
               if (rsp_payload.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %s actual %0d", $time,
                           want.status.name(), rsp_payload.status);
               end
               if (rsp_payload.entry_count !== want.entry_count) begin
                  mismatches++;
                  $display("%0t: entry_count expected %0d actual %0d", $time,
                           want.entry_count, rsp_payload.entry_count);
               end
               if (rsp_payload.is_empty !== want.is_empty) begin
                  mismatches++;
                  $display("%0t: is_empty expected %b actual %b", $time,
                           want.is_empty, rsp_payload.is_empty);
               end
            end
         end
         rx_cycle++;
         rx_mode = rx_mode_type'((rx_cycle / 256) % 4);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
            // long hold: let the unit back up and stall its input
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_FREE:  rsp_ready <= 1'b1;
               RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:  rsp_ready <= ((rx_cycle % 5) != 0);
            endcase
         end
      end
   end

   // Watchdog on cycles without any transfer
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end else begin
            idle_cycles++;
         end
      end
   end

   initial begin
      int seg_left;
      int push_bias;
      int i;

      // Directed: empty pops, fill from both ends starting with extreme words,
      // reject pushes when full, pop from both ends
      add_request(ACT_POP_TAIL, '1);
      add_request(ACT_POP_HEAD, '1);
      add_request(ACT_PUSH_TAIL, '0);
      add_request(ACT_PUSH_HEAD, '1);
      for (i = 0; i < 14; i++) begin
         add_request((i % 2) ? ACT_PUSH_HEAD : ACT_PUSH_TAIL,
                     (i % 2) ? 32'h5A5A_5A5A ^ i : 32'hA5A5_A5A5 ^ (i << 24));
      end
      add_request(ACT_PUSH_TAIL, 32'h1234_5678);
      add_request(ACT_PUSH_HEAD, 32'h8765_4321);
      add_request(ACT_POP_TAIL, '0);
      add_request(ACT_POP_HEAD, '0);
      add_drain_point();

      // Random: segments biased toward filling, draining or balanced
      seg_left = 0;
      push_bias = 5;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 60);
            push_bias = ($urandom_range(0, 2) == 0) ? 8 : (($urandom_range(0, 1) != 0) ? 2 : 5);
         end
         seg_left--;
         if ($urandom_range(0, 9) < push_bias) begin
            add_request($urandom_range(0, 1) ? ACT_PUSH_HEAD : ACT_PUSH_TAIL, random_word());
         end else begin
            add_request($urandom_range(0, 1) ? ACT_POP_HEAD : ACT_POP_TAIL, random_word());
         end
         if (i == 800 || i == 1400) begin
            add_drain_point();
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (queued_requests.size() != 0 || req_valid) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d pushes and %0d pops; %0d pushes hit a full queue, %0d pops an empty one.",
               push_total, pop_total, full_rejects, empty_pops);
      $display("Peak fill %0d of %0d entries, %0d results checked, %0d mismatches.",
               peak_fill, DEPTH, results_seen, mismatches);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_datapath.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_unit.sv
hw/rtl/deq_checker.sv
tb/double_ended_queue_unit_tb.sv
